@@ design/plq_pkg.sv @@
// Shared constants and types for the plane point and line query block.
`timescale 1ns / 1ps
package plq_pkg;

   localparam int NORM_W     = 16;   // normal component, Q2.14
   localparam int COORD_W    = 32;   // coordinates and distances, Q16.16
   localparam int DIST_W     = 31;   // absolute distance and tolerances
   localparam int FRAC_W     = 14;   // extra fraction bits of the Q.30 products
   localparam int DIR_W      = COORD_W + 1;
   localparam int NP_W       = NORM_W + COORD_W;
   localparam int ND_W       = NORM_W + DIR_W;
   localparam int SUM_W      = 51;   // plane sums S and g
   localparam int MAG_W      = SUM_W - 1;
   localparam int DQ_W       = 37;   // rounded distance before saturation
   localparam int NDQ_W      = NORM_W + DQ_W;
   localparam int PT_W       = 56;   // projection and reflection in Q.30
   localparam int RND_W      = PT_W - FRAC_W + 1;
   localparam int HALF_W     = MAG_W / 2;
   localparam int PP_W       = DIR_W + HALF_W;
   localparam int PROD_W     = DIR_W + MAG_W;
   localparam int QUO_W      = 34;   // quotient bits before clamping
   localparam int FIN_W      = QUO_W + 3;
   localparam int DIV_LAT    = QUO_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [1:0] REQ_PROJECT   = 2'd0;
   localparam logic [1:0] REQ_REFLECT   = 2'd1;
   localparam logic [1:0] REQ_INTERSECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_TOL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAR_TOL   = 3'd5;

   typedef struct packed {
      logic [NORM_W-1:0]  nx;
      logic [NORM_W-1:0]  ny;
      logic [NORM_W-1:0]  nz;
      logic [COORD_W-1:0] offset;
      logic [DIST_W-1:0]  on_tol;
      logic [DIST_W-1:0]  par_tol;
   } plane_cfg_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic [2:0][COORD_W-1:0]  p;
      logic [2:0][DIR_W-1:0]    dir;
      logic [SUM_W-1:0]         s;
      logic [DQ_W-1:0]          dq;
      logic [MAG_W-1:0]         g_mag;
      logic                     g_neg;
      logic                     parallel;
   } front_item_type;

   typedef struct packed {
      logic [COORD_W-1:0]       sdist;
      logic [DIST_W-1:0]        absd;
      logic                     on_plane;
      logic                     pvalid;
      logic                     isect;
      logic [2:0]               neg;
      logic [2:0][COORD_W-1:0]  base;
   } side_info_type;

endpackage

@@ design/plq_front.sv @@
// Front end: accepts requests and forms the plane sums, distance and parallel test.
`timescale 1ns / 1ps
module plq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  plq_pkg::plane_cfg_type        cfg,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    req_type,
   input  logic signed [plq_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [plq_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [plq_pkg::COORD_W-1:0] req_start_z,
   input  logic signed [plq_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [plq_pkg::COORD_W-1:0] req_end_y,
   input  logic signed [plq_pkg::COORD_W-1:0] req_end_z,
   output logic                          q_push,
   output plq_pkg::front_item_type       q_data,
   input  logic                          q_full
);

   logic signed [plq_pkg::NORM_W-1:0]  n [3];
   logic signed [plq_pkg::COORD_W-1:0] p_in [3];
   logic signed [plq_pkg::COORD_W-1:0] e_in [3];
   logic signed [plq_pkg::NP_W-1:0]    np_in [3];
   logic signed [plq_pkg::DIR_W-1:0]   dir_in [3];
   logic signed [plq_pkg::ND_W-1:0]    nd_in [3];
   logic signed [plq_pkg::SUM_W-1:0]   s_in;
   logic signed [plq_pkg::SUM_W-1:0]   g_sum;
   logic [plq_pkg::MAG_W-1:0]          s_mag;
   logic [plq_pkg::MAG_W-1:0]          s_rnd;
   logic [plq_pkg::MAG_W-1:0]          g_mag;
   logic [plq_pkg::MAG_W-1:0]          par_lim;
   logic signed [plq_pkg::DQ_W-1:0]    dq_in;
   plq_pkg::front_item_type            item_in;
   logic fe;
   logic accept;

   logic                               f1_valid_ff;
   logic [1:0]                         f1_kind_ff;
   logic signed [plq_pkg::COORD_W-1:0] f1_p_ff [3];
   logic signed [plq_pkg::DIR_W-1:0]   f1_dir_ff [3];
   logic signed [plq_pkg::NP_W-1:0]    f1_np_ff [3];

   logic                               f2_valid_ff;
   logic [1:0]                         f2_kind_ff;
   logic signed [plq_pkg::COORD_W-1:0] f2_p_ff [3];
   logic signed [plq_pkg::DIR_W-1:0]   f2_dir_ff [3];
   logic signed [plq_pkg::SUM_W-1:0]   f2_s_ff;
   logic signed [plq_pkg::ND_W-1:0]    f2_nd_ff [3];

   logic                               f3_valid_ff;
   plq_pkg::front_item_type            f3_item_ff;

   // The whole front stalls together when its last stage cannot enter the queue.
   assign fe     = ~(f3_valid_ff & q_full);
   assign full   = ~fe;
   assign accept = push & fe;
   assign q_push = f3_valid_ff & ~q_full;
   assign q_data = f3_item_ff;

   always_comb begin
      n[0]    = $signed(cfg.nx);
      n[1]    = $signed(cfg.ny);
      n[2]    = $signed(cfg.nz);
      p_in[0] = req_start_x;
      p_in[1] = req_start_y;
      p_in[2] = req_start_z;
      e_in[0] = req_end_x;
      e_in[1] = req_end_y;
      e_in[2] = req_end_z;
      for (int i = 0; i < 3; i++) begin
         np_in[i]  = plq_pkg::NP_W'(n[i]) * plq_pkg::NP_W'(p_in[i]);
         dir_in[i] = plq_pkg::DIR_W'(e_in[i]) - plq_pkg::DIR_W'(p_in[i]);
         nd_in[i]  = plq_pkg::ND_W'(n[i]) * plq_pkg::ND_W'(f1_dir_ff[i]);
      end
      s_in = plq_pkg::SUM_W'(f1_np_ff[0]) + plq_pkg::SUM_W'(f1_np_ff[1])
           + plq_pkg::SUM_W'(f1_np_ff[2])
           + (plq_pkg::SUM_W'($signed(cfg.offset)) <<< plq_pkg::FRAC_W);
   end

   // Distance rounded half away from zero and the parallel test.
   always_comb begin
      g_sum   = plq_pkg::SUM_W'(f2_nd_ff[0]) + plq_pkg::SUM_W'(f2_nd_ff[1])
              + plq_pkg::SUM_W'(f2_nd_ff[2]);
      s_mag   = plq_pkg::MAG_W'(f2_s_ff < 0 ? -f2_s_ff : f2_s_ff);
      s_rnd   = (s_mag + plq_pkg::MAG_W'(1 << (plq_pkg::FRAC_W - 1))) >> plq_pkg::FRAC_W;
      dq_in   = f2_s_ff[plq_pkg::SUM_W-1] ? -$signed(plq_pkg::DQ_W'(s_rnd))
                                         : $signed(plq_pkg::DQ_W'(s_rnd));
      g_mag   = plq_pkg::MAG_W'(g_sum < 0 ? -g_sum : g_sum);
      par_lim = plq_pkg::MAG_W'({cfg.par_tol, plq_pkg::FRAC_W'(0)});
      item_in.kind     = f2_kind_ff;
      for (int i = 0; i < 3; i++) begin
         item_in.p[i]   = f2_p_ff[i];
         item_in.dir[i] = f2_dir_ff[i];
      end
      item_in.s        = f2_s_ff;
      item_in.dq       = dq_in;
      item_in.g_mag    = g_mag;
      item_in.g_neg    = g_sum[plq_pkg::SUM_W-1];
      item_in.parallel = (g_mag < par_lim) | (g_mag == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (fe) begin
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         f1_kind_ff <= req_type;
         f2_kind_ff <= f1_kind_ff;
         f2_s_ff    <= s_in;
         f3_item_ff <= item_in;
         for (int i = 0; i < 3; i++) begin
            f1_p_ff[i]   <= p_in[i];
            f1_dir_ff[i] <= dir_in[i];
            f1_np_ff[i]  <= np_in[i];
            f2_p_ff[i]   <= f1_p_ff[i];
            f2_dir_ff[i] <= f1_dir_ff[i];
            f2_nd_ff[i]  <= nd_in[i];
         end
      end
   end

endmodule

@@ design/plq_queue.sv @@
// Short register queue between the front end and the back end.
`timescale 1ns / 1ps
module plq_queue #(
   parameter int DEPTH = plq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  plq_pkg::front_item_type push_data,
   output logic                    full,
   input  logic                    pop,
   output plq_pkg::front_item_type pop_data,
   output logic                    empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   plq_pkg::front_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count above depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue read while empty");

endmodule

@@ design/plq_div_lane.sv @@
// Pipelined restoring divider lane: rounded quotient, clamped at 2^QUO_W.
`timescale 1ns / 1ps
module plq_div_lane #(
   parameter int NUM_W = plq_pkg::PROD_W,
   parameter int DEN_W = plq_pkg::MAG_W,
   parameter int QUO_W = plq_pkg::QUO_W
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W:0]   quo
);

   localparam int R_W = DEN_W + 1;

   logic [R_W-1:0]   r_ff   [QUO_W+1];
   logic [QUO_W-1:0] low_ff [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic             ovf_ff [QUO_W+1];
   logic [R_W-1:0]   r_in   [QUO_W+1];
   logic [QUO_W-1:0] q_in   [QUO_W+1];
   logic [R_W-1:0]   trial;
   logic [R_W-1:0]   r0;
   logic             rnd;
   logic [QUO_W:0]   quo_ff, quo_in;

   assign quo = quo_ff;
   assign r0  = R_W'(num >> QUO_W);

   // One quotient bit per stage; the remainder stays below the divisor.
   always_comb begin
      trial = '0;
      r_in[0] = r0;
      q_in[0] = '0;
      for (int k = 1; k <= QUO_W; k++) begin
         trial = {r_ff[k-1][R_W-2:0], low_ff[k-1][QUO_W-1]};
         if (trial >= R_W'(den_ff[k-1])) begin
            r_in[k] = trial - R_W'(den_ff[k-1]);
            q_in[k] = {q_ff[k-1][QUO_W-2:0], 1'b1};
         end else begin
            r_in[k] = trial;
            q_in[k] = {q_ff[k-1][QUO_W-2:0], 1'b0};
         end
      end
      rnd = {r_ff[QUO_W], 1'b0} >= (R_W + 1)'(den_ff[QUO_W]);
      if (ovf_ff[QUO_W]) begin
         quo_in = (QUO_W + 1)'(1) << QUO_W;
      end else begin
         quo_in = (QUO_W + 1)'(q_ff[QUO_W]) + (QUO_W + 1)'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= r_in[0];
         q_ff[0]   <= q_in[0];
         low_ff[0] <= num[QUO_W-1:0];
         den_ff[0] <= den;
         ovf_ff[0] <= r0 >= R_W'(den);
         for (int k = 1; k <= QUO_W; k++) begin
            r_ff[k]   <= r_in[k];
            q_ff[k]   <= q_in[k];
            low_ff[k] <= low_ff[k-1] << 1;
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
         quo_ff <= quo_in;
      end
   end

endmodule

@@ design/plq_back.sv @@
// Back end: result points, segment intersection by division, output register.
`timescale 1ns / 1ps
module plq_back (
   input  logic                          clock,
   input  logic                          reset,
   input  plq_pkg::plane_cfg_type        cfg,
   input  logic                          q_empty,
   input  plq_pkg::front_item_type       q_data,
   output logic                          q_pop,
   input  logic                          pop,
   output logic                          empty,
   output logic signed [plq_pkg::COORD_W-1:0] rsp_signed_distance,
   output logic [plq_pkg::DIST_W-1:0]    rsp_abs_distance,
   output logic                          rsp_on_plane,
   output logic                          rsp_point_valid,
   output logic signed [plq_pkg::COORD_W-1:0] rsp_result_x,
   output logic signed [plq_pkg::COORD_W-1:0] rsp_result_y,
   output logic signed [plq_pkg::COORD_W-1:0] rsp_result_z
);

   localparam int L = plq_pkg::DIV_LAT;

   logic be;
   logic signed [plq_pkg::NORM_W-1:0]  n [3];
   logic signed [plq_pkg::DQ_W-1:0]    dq;
   logic [plq_pkg::DQ_W-1:0]           dq_mag;
   logic signed [plq_pkg::SUM_W-1:0]   s_val;
   logic [plq_pkg::MAG_W-1:0]          s_mag;
   logic [plq_pkg::DIST_W-1:0]         absd_in;
   logic [plq_pkg::COORD_W-1:0]        sdist_in;
   logic signed [plq_pkg::DIR_W-1:0]   dir_v;
   logic [plq_pkg::DIR_W-1:0]          dir_mag [3];
   logic signed [plq_pkg::NDQ_W-1:0]   nd_in [3];
   logic [plq_pkg::PP_W-1:0]           lo_in [3];
   logic [plq_pkg::PP_W-1:0]           hi_in [3];
   logic [2:0]                         neg_in;
   logic                               isect_in;

   logic                               b1_valid_ff;
   logic [1:0]                         b1_kind_ff;
   logic [2:0][plq_pkg::COORD_W-1:0]   b1_p_ff;
   logic signed [plq_pkg::NDQ_W-1:0]   b1_nd_ff [3];
   logic [plq_pkg::PP_W-1:0]           b1_lo_ff [3];
   logic [plq_pkg::PP_W-1:0]           b1_hi_ff [3];
   logic [plq_pkg::MAG_W-1:0]          b1_den_ff;
   logic [plq_pkg::COORD_W-1:0]        b1_sdist_ff;
   logic [plq_pkg::DIST_W-1:0]         b1_absd_ff;
   logic                               b1_on_ff;
   logic                               b1_pvalid_ff;
   logic                               b1_isect_ff;
   logic [2:0]                         b1_neg_ff;

   logic signed [plq_pkg::PT_W-1:0]    pt;
   logic [plq_pkg::PT_W-1:0]           pt_mag;
   logic [plq_pkg::PT_W-1:0]           pt_rnd;
   logic signed [plq_pkg::RND_W-1:0]   pt_r;
   logic [plq_pkg::COORD_W-1:0]        pt_sat;
   logic [plq_pkg::PROD_W-1:0]         num_in [3];
   plq_pkg::side_info_type             side_in;

   logic                               b2_valid_ff;
   logic [plq_pkg::PROD_W-1:0]         b2_num_ff [3];
   logic [plq_pkg::MAG_W-1:0]          b2_den_ff;
   plq_pkg::side_info_type             b2_side_ff;

   logic                               dv_ff [L];
   plq_pkg::side_info_type             side_ff [L];
   logic [plq_pkg::QUO_W:0]            quo [3];

   logic signed [plq_pkg::FIN_W-1:0]   step;
   logic signed [plq_pkg::FIN_W-1:0]   diff;
   logic [plq_pkg::COORD_W-1:0]        res_in [3];
   plq_pkg::side_info_type             last;

   logic                               out_valid_ff;
   logic [plq_pkg::COORD_W-1:0]        out_sdist_ff;
   logic [plq_pkg::DIST_W-1:0]         out_absd_ff;
   logic                               out_on_ff;
   logic                               out_pvalid_ff;
   logic [plq_pkg::COORD_W-1:0]        out_res_ff [3];

   // The back pipeline advances whenever the output register is free or drained.
   assign be    = ~out_valid_ff | pop;
   assign q_pop = be & ~q_empty;
   assign empty = ~out_valid_ff;

   assign rsp_signed_distance = $signed(out_sdist_ff);
   assign rsp_abs_distance    = out_absd_ff;
   assign rsp_on_plane        = out_on_ff;
   assign rsp_point_valid     = out_pvalid_ff;
   assign rsp_result_x        = $signed(out_res_ff[0]);
   assign rsp_result_y        = $signed(out_res_ff[1]);
   assign rsp_result_z        = $signed(out_res_ff[2]);

   // First stage: distances, flags and the partial products of |dir| * |S|.
   always_comb begin
      n[0]   = $signed(cfg.nx);
      n[1]   = $signed(cfg.ny);
      n[2]   = $signed(cfg.nz);
      dq     = $signed(q_data.dq);
      dq_mag = plq_pkg::DQ_W'(dq < 0 ? -dq : dq);
      if (dq_mag > plq_pkg::DQ_W'({plq_pkg::DIST_W{1'b1}})) begin
         absd_in = {plq_pkg::DIST_W{1'b1}};
      end else begin
         absd_in = plq_pkg::DIST_W'(dq_mag);
      end
      if (dq[plq_pkg::DQ_W-1:plq_pkg::COORD_W-1] != '0 &&
          dq[plq_pkg::DQ_W-1:plq_pkg::COORD_W-1] != '1) begin
         sdist_in = dq[plq_pkg::DQ_W-1] ? {1'b1, {(plq_pkg::COORD_W-1){1'b0}}}
                                        : {1'b0, {(plq_pkg::COORD_W-1){1'b1}}};
      end else begin
         sdist_in = dq[plq_pkg::COORD_W-1:0];
      end
      s_val = $signed(q_data.s);
      s_mag = plq_pkg::MAG_W'(s_val < 0 ? -s_val : s_val);
      dir_v = '0;
      for (int i = 0; i < 3; i++) begin
         dir_v      = $signed(q_data.dir[i]);
         dir_mag[i] = plq_pkg::DIR_W'(dir_v < 0 ? -dir_v : dir_v);
         neg_in[i]  = q_data.dir[i][plq_pkg::DIR_W-1] ^ q_data.s[plq_pkg::SUM_W-1]
                    ^ q_data.g_neg;
         nd_in[i]   = plq_pkg::NDQ_W'(n[i]) * plq_pkg::NDQ_W'(dq);
         lo_in[i]   = plq_pkg::PP_W'(dir_mag[i])
                    * plq_pkg::PP_W'(s_mag[plq_pkg::HALF_W-1:0]);
         hi_in[i]   = plq_pkg::PP_W'(dir_mag[i])
                    * plq_pkg::PP_W'(s_mag[plq_pkg::MAG_W-1:plq_pkg::HALF_W]);
      end
      isect_in = (q_data.kind == plq_pkg::REQ_INTERSECT) & ~q_data.parallel;
   end

   // Second stage: projection or reflection point, and the full dividend.
   always_comb begin
      pt = '0;
      pt_mag = '0;
      pt_rnd = '0;
      pt_r = '0;
      pt_sat = '0;
      side_in.sdist    = b1_sdist_ff;
      side_in.absd     = b1_absd_ff;
      side_in.on_plane = b1_on_ff;
      side_in.pvalid   = b1_pvalid_ff;
      side_in.isect    = b1_isect_ff;
      side_in.neg      = b1_neg_ff;
      for (int i = 0; i < 3; i++) begin
         pt = (plq_pkg::PT_W'($signed(b1_p_ff[i])) <<< plq_pkg::FRAC_W)
            - ((b1_kind_ff == plq_pkg::REQ_REFLECT) ?
               (plq_pkg::PT_W'(b1_nd_ff[i]) <<< 1) : plq_pkg::PT_W'(b1_nd_ff[i]));
         pt_mag = plq_pkg::PT_W'(pt < 0 ? -pt : pt);
         pt_rnd = (pt_mag + plq_pkg::PT_W'(1 << (plq_pkg::FRAC_W - 1))) >> plq_pkg::FRAC_W;
         pt_r   = pt[plq_pkg::PT_W-1] ? -$signed(plq_pkg::RND_W'(pt_rnd))
                                      : $signed(plq_pkg::RND_W'(pt_rnd));
         if (pt_r[plq_pkg::RND_W-1:plq_pkg::COORD_W-1] != '0 &&
             pt_r[plq_pkg::RND_W-1:plq_pkg::COORD_W-1] != '1) begin
            pt_sat = pt_r[plq_pkg::RND_W-1] ? {1'b1, {(plq_pkg::COORD_W-1){1'b0}}}
                                            : {1'b0, {(plq_pkg::COORD_W-1){1'b1}}};
         end else begin
            pt_sat = pt_r[plq_pkg::COORD_W-1:0];
         end
         if (b1_isect_ff) begin
            side_in.base[i] = b1_p_ff[i];
         end else if (b1_kind_ff == plq_pkg::REQ_PROJECT ||
                      b1_kind_ff == plq_pkg::REQ_REFLECT) begin
            side_in.base[i] = pt_sat;
         end else begin
            side_in.base[i] = '0;
         end
         num_in[i] = (plq_pkg::PROD_W'(b1_hi_ff[i]) << plq_pkg::HALF_W)
                   + plq_pkg::PROD_W'(b1_lo_ff[i]);
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      plq_div_lane #(
         .NUM_W(plq_pkg::PROD_W),
         .DEN_W(plq_pkg::MAG_W),
         .QUO_W(plq_pkg::QUO_W)
      ) u_div (
         .clock(clock),
         .en   (be),
         .num  (b2_num_ff[i]),
         .den  (b2_den_ff),
         .quo  (quo[i])
      );
   end

   // Final step: start minus the signed rounded quotient, saturated; non-intersections keep their base.
   always_comb begin
      last = side_ff[L-1];
      step = '0;
      diff = '0;
      for (int i = 0; i < 3; i++) begin
         step = last.neg[i] ? -$signed(plq_pkg::FIN_W'(quo[i]))
                            : $signed(plq_pkg::FIN_W'(quo[i]));
         diff = plq_pkg::FIN_W'($signed(last.base[i])) - step;
         if (!last.isect) begin
            res_in[i] = last.base[i];
         end else if (diff[plq_pkg::FIN_W-1:plq_pkg::COORD_W-1] != '0 &&
                      diff[plq_pkg::FIN_W-1:plq_pkg::COORD_W-1] != '1) begin
            res_in[i] = diff[plq_pkg::FIN_W-1] ? {1'b1, {(plq_pkg::COORD_W-1){1'b0}}}
                                               : {1'b0, {(plq_pkg::COORD_W-1){1'b1}}};
         end else begin
            res_in[i] = diff[plq_pkg::COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < L; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (be) begin
         b1_valid_ff  <= ~q_empty;
         b2_valid_ff  <= b1_valid_ff;
         dv_ff[0]     <= b2_valid_ff;
         for (int k = 1; k < L; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         out_valid_ff <= dv_ff[L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         b1_kind_ff   <= q_data.kind;
         b1_p_ff      <= q_data.p;
         b1_den_ff    <= q_data.g_mag;
         b1_sdist_ff  <= sdist_in;
         b1_absd_ff   <= absd_in;
         b1_on_ff     <= isect_in | (absd_in < cfg.on_tol);
         b1_pvalid_ff <= isect_in | (q_data.kind == plq_pkg::REQ_PROJECT) |
                         (q_data.kind == plq_pkg::REQ_REFLECT);
         b1_isect_ff  <= isect_in;
         b1_neg_ff    <= neg_in;
         for (int i = 0; i < 3; i++) begin
            b1_nd_ff[i]  <= nd_in[i];
            b1_lo_ff[i]  <= lo_in[i];
            b1_hi_ff[i]  <= hi_in[i];
            b2_num_ff[i] <= num_in[i];
            out_res_ff[i] <= res_in[i];
         end
         b2_den_ff     <= b1_den_ff;
         b2_side_ff    <= side_in;
         side_ff[0]    <= b2_side_ff;
         for (int k = 1; k < L; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         out_sdist_ff  <= last.sdist;
         out_absd_ff   <= last.absd;
         out_on_ff     <= last.on_plane;
         out_pvalid_ff <= last.pvalid;
      end
   end

endmodule

@@ design/plane_point_line_query_top.sv @@
// Top level of the plane point and line query block: plane registers and the two halves.
`timescale 1ns / 1ps
// A request taken on the request channel passes 3 front stages, the queue, 2 back stages,
// the 36-stage divider lanes and the output register before it shows on the rsp_ ports.
// Throughput: one request per cycle, set by the fully pipelined divider lanes, as long
// as pop keeps the output register drained; a held response stalls the pipeline.
// Reset (synchronous, active high) empties every stage and the queue and loads the plane
// registers with normal (0, 0, 1.0), offset 0 and both tolerances 1.
module plane_point_line_query_top #(
   parameter int QUEUE_DEPTH = plq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel. A request is taken when push is high and full is low.
   input  logic                                push,
   output logic                                full,
   input  logic [1:0]                          req_type,
   input  logic signed [plq_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [plq_pkg::COORD_W-1:0]  req_start_y,
   input  logic signed [plq_pkg::COORD_W-1:0]  req_start_z,
   input  logic signed [plq_pkg::COORD_W-1:0]  req_end_x,
   input  logic signed [plq_pkg::COORD_W-1:0]  req_end_y,
   input  logic signed [plq_pkg::COORD_W-1:0]  req_end_z,
   // Response channel. The oldest response sits on the ports while empty is low.
   output logic                                empty,
   input  logic                                pop,
   output logic signed [plq_pkg::COORD_W-1:0]  rsp_signed_distance,
   output logic [plq_pkg::DIST_W-1:0]          rsp_abs_distance,
   output logic                                rsp_on_plane,
   output logic                                rsp_point_valid,
   output logic signed [plq_pkg::COORD_W-1:0]  rsp_result_x,
   output logic signed [plq_pkg::COORD_W-1:0]  rsp_result_y,
   output logic signed [plq_pkg::COORD_W-1:0]  rsp_result_z,
   // Register write port, always ready.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [plq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [plq_pkg::CSR_DATA_W-1:0]      csr_data
);

   plq_pkg::plane_cfg_type  cfg_ff, cfg_in;
   plq_pkg::front_item_type q_in_data;
   plq_pkg::front_item_type q_out_data;
   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_empty;

   assign csr_ready = 1'b1;

   // Register writes. Software must make writes only while no request is in flight; the
   // block does not enforce it. The pipeline reads the plane registers with no per-request copy.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            plq_pkg::CSR_NORMAL_X: cfg_in.nx      = csr_data[plq_pkg::NORM_W-1:0];
            plq_pkg::CSR_NORMAL_Y: cfg_in.ny      = csr_data[plq_pkg::NORM_W-1:0];
            plq_pkg::CSR_NORMAL_Z: cfg_in.nz      = csr_data[plq_pkg::NORM_W-1:0];
            plq_pkg::CSR_OFFSET:   cfg_in.offset  = csr_data[plq_pkg::COORD_W-1:0];
            plq_pkg::CSR_ON_TOL:   cfg_in.on_tol  = csr_data[plq_pkg::DIST_W-1:0];
            plq_pkg::CSR_PAR_TOL:  cfg_in.par_tol = csr_data[plq_pkg::DIST_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nx      <= '0;
         cfg_ff.ny      <= '0;
         cfg_ff.nz      <= plq_pkg::NORM_W'(1 << plq_pkg::FRAC_W);
         cfg_ff.offset  <= '0;
         cfg_ff.on_tol  <= plq_pkg::DIST_W'(1);
         cfg_ff.par_tol <= plq_pkg::DIST_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end forms S = n.p + d and g = n.(end - start), rounds the distance
   // and decides whether a segment runs parallel to the plane.
   plq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .full       (full),
      .req_type   (req_type),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_start_z(req_start_z),
      .req_end_x  (req_end_x),
      .req_end_y  (req_end_y),
      .req_end_z  (req_end_z),
      .q_push     (q_push),
      .q_data     (q_in_data),
      .q_full     (q_full)
   );

   // The queue lets the front keep taking requests, until the queue fills, while the back
   // end is held by a stalled response consumer.
   plq_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_out_data),
      .empty    (q_empty)
   );

   // The back end builds the projected or reflected point, divides for the
   // intersection point and holds each response in its output register.
   plq_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .q_data             (q_out_data),
      .q_pop              (q_pop),
      .pop                (pop),
      .empty              (empty),
      .rsp_signed_distance(rsp_signed_distance),
      .rsp_abs_distance   (rsp_abs_distance),
      .rsp_on_plane       (rsp_on_plane),
      .rsp_point_valid    (rsp_point_valid),
      .rsp_result_x       (rsp_result_x),
      .rsp_result_y       (rsp_result_y),
      .rsp_result_z       (rsp_result_z)
   );

endmodule

@@ tb/tb_plane_point_line_query_top.sv @@
// Self-checking testbench for the plane point and line query block.
`timescale 1ns / 1ps
module tb_plane_point_line_query_top;

   // The result of one request, as the response channel shows it.
   typedef struct {
      logic signed [31:0] sdist;
      logic [30:0]        absd;
      logic               on_plane;
      logic               pvalid;
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
   } query_answer_type;

   localparam longint HALF_LSB  = 64'd8192;
   localparam longint STEP_CLAMP = 64'd1 << 40;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     DRAIN_CYCLES = 60;
   // Request type code that the block does not define; it still returns distances.
   localparam logic [1:0] REQ_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                push = 1'b0;
   logic                full;
   logic [1:0]          req_type = plq_pkg::REQ_PROJECT;
   logic signed [31:0]  req_start_x = '0;
   logic signed [31:0]  req_start_y = '0;
   logic signed [31:0]  req_start_z = '0;
   logic signed [31:0]  req_end_x = '0;
   logic signed [31:0]  req_end_y = '0;
   logic signed [31:0]  req_end_z = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic signed [31:0]  rsp_signed_distance;
   logic [30:0]         rsp_abs_distance;
   logic                rsp_on_plane;
   logic                rsp_point_valid;
   logic signed [31:0]  rsp_result_x;
   logic signed [31:0]  rsp_result_y;
   logic signed [31:0]  rsp_result_z;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [plq_pkg::CSR_IDX_W-1:0]  csr_index = plq_pkg::CSR_NORMAL_X;
   logic [plq_pkg::CSR_DATA_W-1:0] csr_data = '0;

   plane_point_line_query_top u_top (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_type(req_type),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_start_z(req_start_z),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_end_z(req_end_z),
      .empty(empty), .pop(pop),
      .rsp_signed_distance(rsp_signed_distance), .rsp_abs_distance(rsp_abs_distance),
      .rsp_on_plane(rsp_on_plane), .rsp_point_valid(rsp_point_valid),
      .rsp_result_x(rsp_result_x), .rsp_result_y(rsp_result_y),
      .rsp_result_z(rsp_result_z),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Period of 4 ns.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Our own copy of the plane registers, loaded with the reset values.
   logic signed [15:0] plane_nx = 16'sd0;
   logic signed [15:0] plane_ny = 16'sd0;
   logic signed [15:0] plane_nz = 16'sd16384;
   logic signed [31:0] plane_d = 32'sd0;
   logic [30:0]        plane_on_tol = 31'd1;
   logic [30:0]        plane_par_tol = 31'd1;

   query_answer_type pending_answers[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  request_count = 0;
   int  answer_count = 0;
   int  kind_count[4] = '{0, 0, 0, 0};
   int  parallel_count = 0;
   int  send_gap_max = 4;
   int  pop_gap_max = 4;
   int  pop_wait = 0;

   // Timeout guard, counted from the start of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("plane_point_line_query_top verification failed");
         $finish;
      end
   end

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Divide by 2^14, rounding half away from zero.
   function automatic longint drop_q30(longint v);
      longint m;
      m = (magnitude(v) + HALF_LSB) >>> 14;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Expected answer of one request against the current plane.
   function automatic query_answer_type plane_query(logic [1:0] kind,
         longint sx, longint sy, longint sz, longint ex, longint ey, longint ez);
      query_answer_type a;
      longint nrm[3], pt[3], dir[3], res[3];
      longint s, dq, absd, g, stepv;
      bit [127:0] prod, quo, rem, gm;
      bit neg;
      nrm[0] = longint'(plane_nx); nrm[1] = longint'(plane_ny);
      nrm[2] = longint'(plane_nz);
      pt[0] = sx; pt[1] = sy; pt[2] = sz;
      dir[0] = ex - sx; dir[1] = ey - sy; dir[2] = ez - sz;
      res[0] = 0; res[1] = 0; res[2] = 0;
      s = nrm[0] * pt[0] + nrm[1] * pt[1] + nrm[2] * pt[2] + longint'(plane_d) * 16384;
      dq = drop_q30(s);
      absd = magnitude(dq);
      if (absd > 64'sd2147483647) absd = 64'sd2147483647;
      a.on_plane = (absd < longint'(plane_on_tol));
      a.pvalid = 1'b0;
      if (kind == plq_pkg::REQ_PROJECT || kind == plq_pkg::REQ_REFLECT) begin
         for (int i = 0; i < 3; i++) begin
            res[i] = clamp32(drop_q30(pt[i] * 16384
                     - ((kind == plq_pkg::REQ_REFLECT) ? 2 : 1) * nrm[i] * dq));
         end
         a.pvalid = 1'b1;
      end else if (kind == plq_pkg::REQ_INTERSECT) begin
         g = nrm[0] * dir[0] + nrm[1] * dir[1] + nrm[2] * dir[2];
         if (g != 0 && magnitude(g) >= (longint'(plane_par_tol) <<< 14)) begin
            gm = 128'(magnitude(g));
            for (int i = 0; i < 3; i++) begin
               prod = 128'(magnitude(dir[i])) * 128'(magnitude(s));
               quo = prod / gm;
               rem = prod % gm;
               if (2 * rem >= gm) quo++;
               if (quo > 128'(STEP_CLAMP)) quo = 128'(STEP_CLAMP);
               neg = ((dir[i] < 0) != (s < 0)) != (g < 0);
               stepv = neg ? -longint'(quo) : longint'(quo);
               res[i] = clamp32(pt[i] - stepv);
            end
            a.pvalid = 1'b1;
            a.on_plane = 1'b1;
         end
      end
      a.sdist = 32'(clamp32(dq));
      a.absd = absd[30:0];
      a.rx = 32'(res[0]);
      a.ry = 32'(res[1]);
      a.rz = 32'(res[2]);
      return a;
   endfunction

   // Send one request: idle for a random gap, then hold push until it is taken.
   task automatic send_request(logic [1:0] kind, logic [31:0] sx, logic [31:0] sy,
         logic [31:0] sz, logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
      int gap;
      query_answer_type a;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      push <= 1'b1;
      req_type <= kind;
      req_start_x <= sx; req_start_y <= sy; req_start_z <= sz;
      req_end_x <= ex; req_end_y <= ey; req_end_z <= ez;
      do @(posedge clock); while (full);
      a = plane_query(kind, longint'(signed'(sx)), longint'(signed'(sy)),
                      longint'(signed'(sz)), longint'(signed'(ex)),
                      longint'(signed'(ey)), longint'(signed'(ez)));
      if (kind == plq_pkg::REQ_INTERSECT && !a.pvalid) parallel_count++;
      pending_answers.push_back(a);
      kind_count[kind]++;
      request_count++;
   endtask

   // Pop side: after each taken response, stall for a random number of cycles.
   always @(negedge clock) begin
      if (pop_wait > 0) begin
         pop <= 1'b0;
         pop_wait <= pop_wait - 1;
      end else begin
         pop <= 1'b1;
      end
   end

   // Response checker: compare each taken response against the oldest prediction.
   always @(posedge clock) begin
      query_answer_type a;
      if (!reset && pop && !empty) begin
         pop_wait <= $urandom_range(0, pop_gap_max);
         answer_count++;
         if (pending_answers.size() == 0) begin
            $error("Response with no request outstanding");
            error_count++;
         end else begin
            a = pending_answers.pop_front();
            if (rsp_signed_distance !== a.sdist) begin
               $error("signed_distance expected %0d actual %0d", a.sdist,
                      rsp_signed_distance);
               error_count++;
            end
            if (rsp_abs_distance !== a.absd) begin
               $error("abs_distance expected %0d actual %0d", a.absd, rsp_abs_distance);
               error_count++;
            end
            if (rsp_on_plane !== a.on_plane) begin
               $error("on_plane expected %0d actual %0d", a.on_plane, rsp_on_plane);
               error_count++;
            end
            if (rsp_point_valid !== a.pvalid) begin
               $error("point_valid expected %0d actual %0d", a.pvalid, rsp_point_valid);
               error_count++;
            end
            if (rsp_result_x !== a.rx) begin
               $error("result_x expected %0d actual %0d", a.rx, rsp_result_x);
               error_count++;
            end
            if (rsp_result_y !== a.ry) begin
               $error("result_y expected %0d actual %0d", a.ry, rsp_result_y);
               error_count++;
            end
            if (rsp_result_z !== a.rz) begin
               $error("result_z expected %0d actual %0d", a.rz, rsp_result_z);
               error_count++;
            end
         end
      end
   end

   // Wait until every predicted response has come back and the pipe has gone quiet.
   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write, only issued while the block is drained.
   task automatic write_register(logic [plq_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         plq_pkg::CSR_NORMAL_X: plane_nx = value[15:0];
         plq_pkg::CSR_NORMAL_Y: plane_ny = value[15:0];
         plq_pkg::CSR_NORMAL_Z: plane_nz = value[15:0];
         plq_pkg::CSR_OFFSET:   plane_d = value;
         plq_pkg::CSR_ON_TOL:   plane_on_tol = value[30:0];
         plq_pkg::CSR_PAR_TOL:  plane_par_tol = value[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_plane(int nx, int ny, int nz, logic [31:0] d,
         logic [31:0] on_tol, logic [31:0] par_tol);
      drain();
      write_register(plq_pkg::CSR_NORMAL_X, 32'(nx));
      write_register(plq_pkg::CSR_NORMAL_Y, 32'(ny));
      write_register(plq_pkg::CSR_NORMAL_Z, 32'(nz));
      write_register(plq_pkg::CSR_OFFSET, d);
      write_register(plq_pkg::CSR_ON_TOL, on_tol);
      write_register(plq_pkg::CSR_PAR_TOL, par_tol);
   endtask

   // Mostly modest coordinates, sometimes full range or an extreme.
   function automatic logic [31:0] draw_coord();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
         default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      endcase
   endfunction

   // A random request; segments usually run a modest step from their start so that
   // many of them cross the plane instead of overflowing.
   task automatic send_random_request();
      logic [1:0]  kind;
      logic [31:0] sx, sy, sz, ex, ey, ez;
      kind = ($urandom_range(0, 19) == 0) ? REQ_SPARE : 2'($urandom_range(0, 2));
      sx = draw_coord(); sy = draw_coord(); sz = draw_coord();
      if ($urandom_range(0, 3) == 0) begin
         ex = draw_coord(); ey = draw_coord(); ez = draw_coord();
      end else begin
         ex = sx + 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
         ey = sy + 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
         ez = (sz ^ 32'h8000_0000) - 32'h8000_0000
              - 32'($urandom_range(0, 32'h0010_0000));
         if ($urandom_range(0, 1)) ez = sz + 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
      end
      send_request(kind, sx, sy, sz, ex, ey, ez);
   endtask

   // Reset values of the plane: the xy plane with unit tolerances.
   task automatic test_reset_plane();
      send_request(plq_pkg::REQ_PROJECT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                   0, 0, 0);
      send_request(plq_pkg::REQ_REFLECT, 32'h0001_0000, 32'hFFFE_0000, 32'hFFFD_8000,
                   0, 0, 0);
      send_request(plq_pkg::REQ_INTERSECT, 0, 0, 32'h0001_0000, 32'h0001_0000, 0,
                   32'hFFFF_0000);
      send_request(plq_pkg::REQ_PROJECT, 32'h1234_5678, 32'h8765_4321, 0, 0, 0, 0);
   endtask

   // Field extremes, saturation of every output and the unused request type.
   task automatic test_extremes();
      set_plane(-16384, 16384, 16384, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(plq_pkg::REQ_PROJECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   0, 0, 0);
      send_request(plq_pkg::REQ_REFLECT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   0, 0, 0);
      send_request(plq_pkg::REQ_REFLECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   0, 0, 0);
      send_request(REQ_SPARE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      set_plane(16384, -16384, -16384, 32'h8000_0000, 0, 0);
      send_request(plq_pkg::REQ_PROJECT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   0, 0, 0);
      send_request(plq_pkg::REQ_INTERSECT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(plq_pkg::REQ_INTERSECT, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFE, 0, 0);
      send_request(REQ_SPARE, 0, 0, 0, 0, 0, 0);
   endtask

   // Parallel segments (in the plane and off it), zero-length segments and crossings.
   task automatic test_segments();
      set_plane(0, 0, 16384, 32'hFFFF_0000, 32'h0000_0100, 32'h0000_0001);
      send_request(plq_pkg::REQ_INTERSECT, 0, 0, 32'h0001_0000, 32'h0005_0000, 0,
                   32'h0001_0000);
      send_request(plq_pkg::REQ_INTERSECT, 0, 0, 32'h0001_0040, 32'h0005_0000, 0,
                   32'h0001_0040);
      send_request(plq_pkg::REQ_INTERSECT, 32'h0003_0000, 0, 32'h0002_0000,
                   32'h0003_0000, 0, 32'h0002_0000);
      send_request(plq_pkg::REQ_INTERSECT, 32'h0001_0000, 32'h0001_0000, 32'h0004_0000,
                   32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
      send_request(plq_pkg::REQ_INTERSECT, 0, 0, 32'h0000_8000, 0, 0, 32'h0000_8001);
      send_request(plq_pkg::REQ_PROJECT, 0, 0, 32'h0001_0000, 0, 0, 0);
      send_request(plq_pkg::REQ_REFLECT, 0, 0, 32'h0001_0080, 0, 0, 0);
   endtask

   // Random requests against a series of planes, some with no idling at all.
   task automatic test_random_planes();
      for (int phase = 0; phase < 6; phase++) begin
         set_plane($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                   $urandom_range(0, 32768) - 16384,
                   (phase == 5) ? $urandom : 32'($urandom_range(0, 32'h0100_0000)) - 32'h80_0000,
                   (phase == 4) ? $urandom : 32'($urandom_range(0, 32'h0008_0000)),
                   (phase == 3) ? $urandom : 32'($urandom_range(0, 32'h0000_4000)));
         send_gap_max = (phase == 2) ? 0 : 4;
         pop_gap_max = (phase == 2 || phase == 4) ? 0 : 4;
         repeat (300) send_random_request();
      end
      send_gap_max = 4;
      pop_gap_max = 4;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_plane();
      test_extremes();
      test_segments();
      test_random_planes();
      drain();
      $display("Checked %0d responses to %0d requests: %0d project, %0d reflect,",
               answer_count, request_count, kind_count[0], kind_count[1]);
      $display("%0d intersect (%0d parallel), %0d of the unused type, over 10 planes.",
               kind_count[2], parallel_count, kind_count[3]);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("plane_point_line_query_top verification clean");
      end else begin
         $display("plane_point_line_query_top verification failed");
      end
      $finish;
   end

endmodule
